[rtl/core/noncontinuous_rastrigin_eval_assert.svh]
// Assertion macros shared by the noncontinuous Rastrigin evaluator RTL.
`ifndef NONCONTINUOUS_RASTRIGIN_EVAL_ASSERT_SVH
`define NONCONTINUOUS_RASTRIGIN_EVAL_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NRE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nre: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define NRE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nre: next-cycle check failed");

`endif

[rtl/core/nre_pkg.sv]
// Package: shared widths, constants and elaboration-time cosine helper.
package nre_pkg;

    localparam int X_W   = 16;
    localparam int OBJ_W = 32;
    localparam int SUM_W = 40;

    localparam logic [63:0]      PI_Q30  = 64'd3373259426;
    localparam logic [63:0]      ONE_Q30 = 64'd1073741824;
    localparam logic [SUM_W-1:0] SUM_MAX = 40'h7F_FFFF_FFFF;

    // Width of one element term for a given number of fraction bits.
    function automatic int term_w(input int f);
        return (((33 - f) > (f + 5)) ? (33 - f) : (f + 5)) + 1;
    endfunction

    // Q2.30 cosine by truncated Taylor series, clamped to [0, 1].
    function automatic logic [63:0] cos_q30(input logic [63:0] t);
        logic [63:0]        t2;
        logic [63:0]        mag;
        logic signed [63:0] acc;
        int                 k;
        t2  = (t * t) >> 30;
        mag = ONE_Q30;
        acc = signed'(ONE_Q30);
        for (k = 1; k <= 11; k++) begin
            mag = ((mag * t2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k[0]) begin
                acc = acc - signed'(mag);
            end else begin
                acc = acc + signed'(mag);
            end
        end
        if (acc < 0) begin
            acc = '0;
        end
        if (acc > signed'(ONE_Q30)) begin
            acc = signed'(ONE_Q30);
        end
        return unsigned'(acc);
    endfunction

endpackage

[rtl/core/nre_prep.sv]
// First compute stage: magnitude, half rounding, squares and table step.
module nre_prep #(
    parameter int FRAC_BITS         = 12,
    parameter int COS_TABLE_ENTRIES = 256,
    localparam int TERM_W = nre_pkg::term_w(FRAC_BITS),
    localparam int SQ_W   = FRAC_BITS - 1,
    localparam int Q_W    = $clog2(2 * COS_TABLE_ENTRIES + 1)
) (
    input  logic signed [nre_pkg::X_W-1:0] i_x_value,
    output logic                           o_rounded,
    output logic [TERM_W-1:0]              o_rnd_term,
    output logic [SQ_W-1:0]                o_sq_small,
    output logic [Q_W-1:0]                 o_q
);

    localparam int RW   = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
    localparam int KW   = RW - FRAC_BITS;
    localparam int QP_W = nre_pkg::X_W + $clog2(4 * COS_TABLE_ENTRIES + 1);
    localparam int QS_W = ((QP_W > FRAC_BITS) ? QP_W : FRAC_BITS) + 1;
    localparam logic [RW-1:0] HALF_R = RW'(1) << (FRAC_BITS - 1);

    logic [nre_pkg::X_W-1:0]   a;
    logic [RW-1:0]             a_ext;
    logic [RW-1:0]             k_sum;
    logic [KW-1:0]             k;
    logic [2*KW-1:0]           k_sq;
    logic [2*nre_pkg::X_W-1:0] a_sq;
    logic [2*nre_pkg::X_W:0]   sqs_sum;
    logic [QS_W-1:0]           q_sum;
    logic [QS_W-1:0]           q_sh;

    always_comb begin
        a = i_x_value[nre_pkg::X_W-1] ? (nre_pkg::X_W'(0) - unsigned'(i_x_value))
                                      : unsigned'(i_x_value);
        a_ext     = RW'(a);
        o_rounded = (a_ext >= HALF_R);

        // nearest half, ties away from zero: k = round(2|x|)
        k_sum = (a_ext << 1) + HALF_R;
        k     = KW'(k_sum >> FRAC_BITS);
        k_sq  = k * k;
        o_rnd_term = (TERM_W'(k_sq) << (FRAC_BITS - 2))
                   + (k[0] ? (TERM_W'(20) << FRAC_BITS) : TERM_W'(0));

        a_sq       = a * a;
        sqs_sum    = (2 * nre_pkg::X_W + 1)'(a_sq) + (2 * nre_pkg::X_W + 1)'(HALF_R);
        o_sq_small = SQ_W'(sqs_sum >> FRAC_BITS);

        q_sum = QS_W'(a) * QS_W'(4 * COS_TABLE_ENTRIES) + QS_W'(HALF_R);
        q_sh  = q_sum >> FRAC_BITS;
        o_q   = (q_sh > QS_W'(2 * COS_TABLE_ENTRIES)) ? Q_W'(2 * COS_TABLE_ENTRIES)
                                                      : Q_W'(q_sh);
    end

endmodule

[rtl/core/nre_term.sv]
// Second compute stage: quarter-wave cosine lookup and element term.
module nre_term #(
    parameter int FRAC_BITS         = 12,
    parameter int COS_TABLE_ENTRIES = 256,
    localparam int TERM_W = nre_pkg::term_w(FRAC_BITS),
    localparam int SQ_W   = FRAC_BITS - 1,
    localparam int Q_W    = $clog2(2 * COS_TABLE_ENTRIES + 1)
) (
    input  logic              i_rounded,
    input  logic [TERM_W-1:0] i_rnd_term,
    input  logic [SQ_W-1:0]   i_sq_small,
    input  logic [Q_W-1:0]    i_q,
    output logic [TERM_W-1:0] o_term
);

    localparam int TC_W  = FRAC_BITS + 4;
    localparam int IDX_W = $clog2(COS_TABLE_ENTRIES + 1);
    localparam int SH    = 30 - FRAC_BITS;

    // 10*cos already scaled to FRAC_BITS, ties away from zero on magnitude
    logic [TC_W-1:0] tc_tab [COS_TABLE_ENTRIES+1];

    for (genvar gi = 0; gi <= COS_TABLE_ENTRIES; gi++) begin : g_tab
        localparam logic [63:0] ANGLE =
            (64'(gi) * nre_pkg::PI_Q30 + 64'(COS_TABLE_ENTRIES)) /
            64'(2 * COS_TABLE_ENTRIES);
        localparam logic [63:0] COS_V = nre_pkg::cos_q30(ANGLE);
        localparam logic [63:0] TC_V  = (COS_V * 64'd10 + (64'd1 << (SH - 1))) >> SH;
        assign tc_tab[gi] = TC_W'(TC_V);
    end

    logic              neg;
    logic [IDX_W-1:0]  idx;
    logic [TC_W-1:0]   tc;
    logic [TERM_W-1:0] base;

    always_comb begin
        neg  = (i_q > Q_W'(COS_TABLE_ENTRIES));
        idx  = neg ? IDX_W'(Q_W'(2 * COS_TABLE_ENTRIES) - i_q) : IDX_W'(i_q);
        tc   = tc_tab[idx];
        base = TERM_W'(i_sq_small) + (TERM_W'(10) << FRAC_BITS);
        if (i_rounded) begin
            o_term = i_rnd_term;
        end else if (neg) begin
            o_term = base + TERM_W'(tc);
        end else begin
            o_term = base - TERM_W'(tc);
        end
    end

endmodule

[rtl/core/noncontinuous_rastrigin_eval.sv]
// Top level: streaming noncontinuous Rastrigin objective evaluator.
//
// Input channel: one decision variable per word (i_x_value, signed Q3.12 at the
// default FRAC_BITS) with i_is_last marking the final variable of a vector.
// A word is taken on a rising edge with i_valid high and o_stall low.
// Output channel: one word per vector (o_objective, signed Q19.12), taken on a
// rising edge with o_valid high and i_stall low.
// Config: i_cfg_wr_en writes i_cfg_wr_data into the bias register, which is
// added to every finished sum. Write it only while the block is idle.
// Throughput: one input word per cycle if i_stall is low. Five register stages
// (input, prep, term, total, output); each stage advances when the one after
// it is empty or moving, so a stalled result does not block words behind it
// until the pipe fills. Words that are not last never occupy the total stage.
// A vector's last word passes the prep, term and total stages to the output
// stage, which drives o_valid. The per-word critical path is one 16x16 square
// in prep and the 40-bit saturating accumulate in the term-to-total step.
// Reset (synchronous, i_rst_n low) empties the pipe, clears the running sum
// and sets the bias to zero.
module noncontinuous_rastrigin_eval #(
    parameter int FRAC_BITS         = 12,
    parameter int COS_TABLE_ENTRIES = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [nre_pkg::X_W-1:0]   i_x_value,
    input  logic                             i_is_last,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [nre_pkg::OBJ_W-1:0] o_objective,
    input  logic                             i_cfg_wr_en,
    input  logic signed [nre_pkg::OBJ_W-1:0] i_cfg_wr_data
);

    localparam int TERM_W = nre_pkg::term_w(FRAC_BITS);
    localparam int SQ_W   = FRAC_BITS - 1;
    localparam int Q_W    = $clog2(2 * COS_TABLE_ENTRIES + 1);
    localparam int SUM_W  = nre_pkg::SUM_W;
    localparam int FIN_W  = SUM_W + 2;
    localparam logic signed [FIN_W-1:0] OBJ_MAX = FIN_W'(64'sd2147483647);
    localparam logic signed [FIN_W-1:0] OBJ_MIN = FIN_W'(-64'sd2147483648);

    // stage 1: input word
    logic                            r_s1_vld, n_s1_vld;
    logic signed [nre_pkg::X_W-1:0]  r_s1_x, n_s1_x;
    logic                            r_s1_last, n_s1_last;
    // stage 2: prep results
    logic                            r_s2_vld, n_s2_vld;
    logic                            r_s2_last, n_s2_last;
    logic                            r_s2_rounded, n_s2_rounded;
    logic [TERM_W-1:0]               r_s2_rnd_term, n_s2_rnd_term;
    logic [SQ_W-1:0]                 r_s2_sq_small, n_s2_sq_small;
    logic [Q_W-1:0]                  r_s2_q, n_s2_q;
    // stage 3: element term
    logic                            r_s3_vld, n_s3_vld;
    logic                            r_s3_last, n_s3_last;
    logic [TERM_W-1:0]               r_s3_term, n_s3_term;
    // accumulator and stage 4: finished vector total
    logic [SUM_W-1:0]                r_sum, n_sum;
    logic                            r_s4_vld, n_s4_vld;
    logic [SUM_W-1:0]                r_s4_total, n_s4_total;
    // stage 5: output word
    logic                            r_out_vld, n_out_vld;
    logic signed [nre_pkg::OBJ_W-1:0] r_objective, n_objective;
    // config
    logic signed [nre_pkg::OBJ_W-1:0] r_bias, n_bias;

    logic s1_free, s1_go, s2_free, s2_go, s3_free, s3_go, s4_free, s4_go, s5_free;

    logic              p_rounded;
    logic [TERM_W-1:0] p_rnd_term;
    logic [SQ_W-1:0]   p_sq_small;
    logic [Q_W-1:0]    p_q;
    logic [TERM_W-1:0] t_term;

    logic [SUM_W:0]          sum_add;
    logic [SUM_W-1:0]        sum_sat;
    logic signed [FIN_W-1:0] fin;

    nre_prep #(
        .FRAC_BITS        (FRAC_BITS),
        .COS_TABLE_ENTRIES(COS_TABLE_ENTRIES)
    ) u_prep (
        .i_x_value (r_s1_x),
        .o_rounded (p_rounded),
        .o_rnd_term(p_rnd_term),
        .o_sq_small(p_sq_small),
        .o_q       (p_q)
    );

    nre_term #(
        .FRAC_BITS        (FRAC_BITS),
        .COS_TABLE_ENTRIES(COS_TABLE_ENTRIES)
    ) u_term (
        .i_rounded (r_s2_rounded),
        .i_rnd_term(r_s2_rnd_term),
        .i_sq_small(r_s2_sq_small),
        .i_q       (r_s2_q),
        .o_term    (t_term)
    );

    // Stage flow: a stage loads when empty or when its word moves on.
    always_comb begin
        s5_free = !r_out_vld || !i_stall;
        s4_go   = r_s4_vld && s5_free;
        s4_free = !r_s4_vld || s4_go;
        // only a last word needs room in the total stage
        s3_go   = r_s3_vld && (!r_s3_last || s4_free);
        s3_free = !r_s3_vld || s3_go;
        s2_go   = r_s2_vld && s3_free;
        s2_free = !r_s2_vld || s2_go;
        s1_go   = r_s1_vld && s2_free;
        s1_free = !r_s1_vld || s1_go;
    end

    assign o_stall = !s1_free;

    // Saturating accumulate and bias add.
    always_comb begin
        sum_add = {1'b0, r_sum} + (SUM_W + 1)'(r_s3_term);
        sum_sat = (sum_add > (SUM_W + 1)'(nre_pkg::SUM_MAX)) ? nre_pkg::SUM_MAX
                                                             : SUM_W'(sum_add);
        fin = signed'({2'b00, r_s4_total}) + FIN_W'(r_bias);
    end

    always_comb begin
        n_s1_vld  = s1_free ? i_valid : r_s1_vld;
        n_s1_x    = r_s1_x;
        n_s1_last = r_s1_last;
        if (i_valid && s1_free) begin
            n_s1_x    = i_x_value;
            n_s1_last = i_is_last;
        end

        n_s2_vld      = s2_free ? s1_go : r_s2_vld;
        n_s2_last     = r_s2_last;
        n_s2_rounded  = r_s2_rounded;
        n_s2_rnd_term = r_s2_rnd_term;
        n_s2_sq_small = r_s2_sq_small;
        n_s2_q        = r_s2_q;
        if (s1_go) begin
            n_s2_last     = r_s1_last;
            n_s2_rounded  = p_rounded;
            n_s2_rnd_term = p_rnd_term;
            n_s2_sq_small = p_sq_small;
            n_s2_q        = p_q;
        end

        n_s3_vld  = s3_free ? s2_go : r_s3_vld;
        n_s3_last = r_s3_last;
        n_s3_term = r_s3_term;
        if (s2_go) begin
            n_s3_last = r_s2_last;
            n_s3_term = t_term;
        end

        n_sum      = r_sum;
        n_s4_vld   = s4_free ? (s3_go && r_s3_last) : r_s4_vld;
        n_s4_total = r_s4_total;
        if (s3_go) begin
            if (r_s3_last) begin
                n_sum      = '0;
                n_s4_total = sum_sat;
            end else begin
                n_sum = sum_sat;
            end
        end

        n_out_vld   = s5_free ? s4_go : r_out_vld;
        n_objective = r_objective;
        if (s4_go) begin
            if (fin > OBJ_MAX) begin
                n_objective = nre_pkg::OBJ_W'(OBJ_MAX);
            end else if (fin < OBJ_MIN) begin
                n_objective = nre_pkg::OBJ_W'(OBJ_MIN);
            end else begin
                n_objective = nre_pkg::OBJ_W'(fin);
            end
        end

        n_bias = i_cfg_wr_en ? i_cfg_wr_data : r_bias;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_sum     <= '0;
            r_bias    <= '0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_s2_vld  <= n_s2_vld;
            r_s3_vld  <= n_s3_vld;
            r_s4_vld  <= n_s4_vld;
            r_out_vld <= n_out_vld;
            r_sum     <= n_sum;
            r_bias    <= n_bias;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_x        <= n_s1_x;
        r_s1_last     <= n_s1_last;
        r_s2_last     <= n_s2_last;
        r_s2_rounded  <= n_s2_rounded;
        r_s2_rnd_term <= n_s2_rnd_term;
        r_s2_sq_small <= n_s2_sq_small;
        r_s2_q        <= n_s2_q;
        r_s3_last     <= n_s3_last;
        r_s3_term     <= n_s3_term;
        r_s4_total    <= n_s4_total;
        r_objective   <= n_objective;
    end

    assign o_valid     = r_out_vld;
    assign o_objective = r_objective;

`include "noncontinuous_rastrigin_eval_assert.svh"

    // running sum stays within its saturation bound
    `NRE_ASSERT_IMP(a_sum_in_range, i_clk, i_rst_n, 1'b1, r_sum[SUM_W-1] == 1'b0)
    // a last word restarts the sum for the next vector
    `NRE_ASSERT_NXT(a_sum_clears, i_clk, i_rst_n, s3_go && r_s3_last, r_sum == '0)
    // an empty input stage never pushes back
    `NRE_ASSERT_IMP(a_idle_ready, i_clk, i_rst_n, !r_s1_vld, !o_stall)
    // a blocked total is not overwritten
    `NRE_ASSERT_NXT(a_total_holds, i_clk, i_rst_n, r_s4_vld && !s4_go,
                    r_s4_vld && $stable(r_s4_total))

endmodule

[tb/testbench.sv]
// Self-checking testbench for the streaming noncontinuous Rastrigin evaluator.
`timescale 1ns / 100ps

module testbench;

    typedef longint unsigned t_u64;

    localparam int FRAC           = 12;
    localparam int TAB_N          = 256;
    // Headroom after the last expected result, before a bias write, so that
    // trailing non-last words have also settled.
    localparam int DRAIN_CYCLES   = 10;
    // Long output hold-off, enough to back the five-stage pipe up to the input.
    localparam int HOLD_CYCLES    = 80;
    // Cycles with no word moving on either channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;

    localparam t_u64   PI_Q30_C  = 64'd3373259426;
    localparam longint ONE_Q30_C = 64'sd1073741824;
    localparam longint SUM_CEIL  = (64'sd1 <<< 39) - 1;
    localparam longint OBJ_MAX   = 64'sd2147483647;
    localparam longint OBJ_MIN   = -64'sd2147483648;

    // One row of the directed part. Where typed is set, objective is the value
    // read straight off the formula; otherwise the predictor supplies it.
    typedef struct packed {
        logic signed [nre_pkg::X_W-1:0]   x;
        logic                             last;
        logic                             typed;
        logic signed [nre_pkg::OBJ_W-1:0] objective;
    } t_stim_row;

    localparam int N_ROWS = 22;
    localparam t_stim_row DIRECTED_ROWS [N_ROWS] = '{
        // zero: cosine is exactly one, term cancels to zero
        '{16'sd0,      1'b1, 1'b1, 32'sd0},
        // whole numbers, both signs: y*y only
        '{16'sd4096,   1'b1, 1'b1, 32'sd4096},
        '{-16'sd4096,  1'b1, 1'b1, 32'sd4096},
        // exactly one half: rounded branch, odd k adds 20
        '{16'sd2048,   1'b1, 1'b1, 32'sd82944},
        '{-16'sd2048,  1'b1, 1'b1, 32'sd82944},
        // 1.25 rounds away from zero to 1.5 on both signs
        '{16'sd5120,   1'b1, 1'b1, 32'sd91136},
        '{-16'sd5120,  1'b1, 1'b1, 32'sd91136},
        // just under 1.25 rounds down to 1.0
        '{16'sd5119,   1'b1, 1'b1, 32'sd4096},
        // -1.5 stays -1.5 (negative side no longer truncates)
        '{-16'sd6144,  1'b1, 1'b1, 32'sd91136},
        // domain edges +-5.12 round to +-5
        '{16'sd20972,  1'b1, 1'b1, 32'sd102400},
        '{-16'sd20972, 1'b1, 1'b1, 32'sd102400},
        // field extremes beyond the domain: both round to magnitude 8
        '{16'sd32767,  1'b1, 1'b1, 32'sd262144},
        '{-16'sd32768, 1'b1, 1'b1, 32'sd262144},
        // largest magnitudes still on the table path
        '{16'sd2047,   1'b1, 1'b0, 32'sd0},
        '{-16'sd2047,  1'b1, 1'b0, 32'sd0},
        // two multi-word vectors: tiny values, quarter-wave zero, negative half
        '{16'sd1,      1'b0, 1'b0, 32'sd0},
        '{-16'sd1,     1'b0, 1'b0, 32'sd0},
        '{16'sd1024,   1'b0, 1'b0, 32'sd0},
        '{-16'sd1536,  1'b1, 1'b0, 32'sd0},
        '{16'sd0,      1'b0, 1'b0, 32'sd0},
        '{16'sd20972,  1'b0, 1'b0, 32'sd0},
        '{-16'sd3000,  1'b1, 1'b0, 32'sd0}
    };

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_valid;
    logic                             o_stall;
    logic signed [nre_pkg::X_W-1:0]   i_x_value;
    logic                             i_is_last;
    logic                             o_valid;
    logic                             i_stall;
    logic signed [nre_pkg::OBJ_W-1:0] o_objective;
    logic                             i_cfg_wr_en;
    logic signed [nre_pkg::OBJ_W-1:0] i_cfg_wr_data;

    // Travels with each word so the monitor knows whether a typed value applies.
    logic                             drv_typed;
    logic signed [nre_pkg::OBJ_W-1:0] drv_typed_obj;

    // Predictor state
    longint                           cos_lut [0:TAB_N];
    longint                           sum_model;
    longint                           bias_model;
    logic signed [nre_pkg::OBJ_W-1:0] objective_q [$];
    logic signed [nre_pkg::OBJ_W-1:0] objective_want;

    int error_count   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_request  = 1'b0;
    int quiet_cycles  = 0;

    noncontinuous_rastrigin_eval #(
        .FRAC_BITS         (FRAC),
        .COS_TABLE_ENTRIES (TAB_N)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_x_value     (i_x_value),
        .i_is_last     (i_is_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_objective   (o_objective),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Q2.30 cosine of a Q30 angle: Taylor series, each term truncated,
    // clamped to [0, 1].
    function automatic longint quarter_cos_q30(input t_u64 angle);
        t_u64   ang_sq;
        t_u64   mag;
        longint acc;
        int     n;
        ang_sq = (angle * angle) >> 30;
        mag    = t_u64'(ONE_Q30_C);
        acc    = ONE_Q30_C;
        for (n = 1; n <= 11; n++) begin
            mag = ((mag * ang_sq) >> 30) / t_u64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
                acc = acc - longint'(mag);
            end else begin
                acc = acc + longint'(mag);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > ONE_Q30_C) begin
            acc = ONE_Q30_C;
        end
        return acc;
    endfunction

    // One element term y*y + 10 - 10*cos(2*pi*y) at FRAC fraction bits.
    function automatic longint rastrigin_term(input logic signed [nre_pkg::X_W-1:0] x);
        longint a;
        longint k;
        longint sq;
        longint q;
        longint c;
        longint tc;
        longint half;
        half = 64'sd1 <<< (FRAC - 1);
        a    = (x < 0) ? -longint'(x) : longint'(x);
        if (a >= half) begin
            // Round 2x half away from zero; cosine is +1 for even k, -1 for odd.
            k  = (2 * a + half) >>> FRAC;
            sq = (k * k) <<< (FRAC - 2);
            if (k % 2 == 1) begin
                sq = sq + (64'sd20 <<< FRAC);
            end
            return sq;
        end
        sq = (a * a + half) >>> FRAC;
        q  = (a * 4 * TAB_N + half) >>> FRAC;
        if (q > 2 * TAB_N) begin
            q = 2 * TAB_N;
        end
        // Second quarter mirrors the first with the sign flipped.
        c  = (q <= TAB_N) ? cos_lut[q] : -cos_lut[2 * TAB_N - q];
        tc = (((c < 0) ? -c : c) * 10 + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
        if (c < 0) begin
            return sq + (64'sd10 <<< FRAC) + tc;
        end
        return sq + (64'sd10 <<< FRAC) - tc;
    endfunction

    // Fold one accepted word into the running sum; on the last word of a
    // vector queue the objective and clear the sum.
    function automatic void absorb_word(input logic signed [nre_pkg::X_W-1:0]   x,
                                        input logic                             last,
                                        input logic                             typed,
                                        input logic signed [nre_pkg::OBJ_W-1:0] typed_obj);
        longint t;
        longint r;
        t = rastrigin_term(x);
        if (t < 0) begin
            t = 0;
        end
        sum_model = sum_model + t;
        if (sum_model > SUM_CEIL) begin
            sum_model = SUM_CEIL;
        end
        if (last) begin
            r = sum_model + bias_model;
            if (r > OBJ_MAX) begin
                r = OBJ_MAX;
            end
            if (r < OBJ_MIN) begin
                r = OBJ_MIN;
            end
            if (typed) begin
                objective_q.push_back(typed_obj);
            end else begin
                objective_q.push_back(32'(r));
            end
            sum_model = 0;
        end
    endfunction

    // Mix of table-path values, in-domain values, values near half steps
    // and arbitrary 16-bit patterns.
    function automatic logic signed [nre_pkg::X_W-1:0] random_x();
        int unsigned pick;
        int          k;
        pick = $urandom_range(99);
        k    = $urandom_range(20) - 10;
        if (pick < 35) begin
            return 16'($urandom_range(4094) - 2047);
        end else if (pick < 70) begin
            return 16'($urandom_range(41944) - 20972);
        end else if (pick < 85) begin
            return 16'(k * 2048 + $urandom_range(2) - 1);
        end
        return 16'($urandom_range(65535));
    endfunction

    // Offer one word, with a random idle gap ahead of it; returns right after
    // the edge that takes it.
    task automatic send_word(input logic signed [nre_pkg::X_W-1:0]   x,
                             input logic                             last,
                             input logic                             typed,
                             input logic signed [nre_pkg::OBJ_W-1:0] typed_obj);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_x_value     <= x;
        i_is_last     <= last;
        drv_typed     <= typed;
        drv_typed_obj <= typed_obj;
        do begin
            @(posedge i_clk);
        end while (o_stall);
    endtask

    // Random vectors, mostly short, now and then long; every vector closes.
    task automatic send_random_vectors(input int word_goal);
        int sent;
        int len;
        sent = 0;
        while (sent < word_goal) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(24, 10) : $urandom_range(5, 1);
            for (int j = 0; j < len; j++) begin
                send_word(random_x(), (j == len - 1), 1'b0, '0);
            end
            sent += len;
        end
    endtask

    // Stop offering, wait for every expected objective, then let the pipe settle.
    // It waits on the clock first, so the monitor has queued the word taken at the last edge.
    task automatic drain_pipe();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (objective_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_bias(input logic signed [nre_pkg::OBJ_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        bias_model = value;
    endtask

    task automatic run_phase(input logic signed [nre_pkg::OBJ_W-1:0] bias_value,
                             input int                             send_pct,
                             input int                             recv_pct,
                             input int                             word_goal);
        drain_pipe();
        write_bias(bias_value);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        send_random_vectors(word_goal);
    endtask

    // Output side: random stall, or a long hold-off when asked for one.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                repeat (HOLD_CYCLES) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor: both channels sampled at the edge, before any new drive lands.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                absorb_word(i_x_value, i_is_last, drv_typed, drv_typed_obj);
            end
            if (o_valid && !i_stall) begin
                if (objective_q.size() == 0) begin
                    $error("objective word with nothing expected: actual %0d", o_objective);
                    error_count++;
                end else begin
                    objective_want = objective_q.pop_front();
                    if (o_objective !== objective_want) begin
                        $error("objective mismatch: expected %0d, actual %0d",
                               objective_want, o_objective);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: too long with no word moving on either side means a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_x_value     = '0;
        i_is_last     = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        drv_typed     = 1'b0;
        drv_typed_obj = '0;
        sum_model     = 0;
        bias_model    = 0;
        for (int i = 0; i <= TAB_N; i++) begin
            cos_lut[i] = quarter_cos_q30((t_u64'(i) * PI_Q30_C + t_u64'(TAB_N))
                                         / t_u64'(2 * TAB_N));
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows at the reset bias of zero, no idling.
        for (int r = 0; r < N_ROWS; r++) begin
            send_word(DIRECTED_ROWS[r].x, DIRECTED_ROWS[r].last,
                      DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].objective);
        end

        // Bias extremes and random settings across the idling mixes.
        run_phase(32'sh7FFF_FFFF, 0, 0, 250);    // saturates high on any nonzero sum
        run_phase(32'sh8000_0000, 81, 0, 250);   // most negative bias
        run_phase(32'($urandom()), 0, 81, 250);
        run_phase(32'sh7FFF_0000, 36, 36, 250);  // sums cross the top now and then

        // Back-pressure: output held off while words keep coming, pipe fills
        // and the input stalls.
        drain_pipe();
        write_bias(32'($urandom_range(200000)) - 32'sd100000);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 1'b1;
        send_random_vectors(60);

        run_phase(32'sd0, 36, 36, 250);
        run_phase(32'($urandom_range(65535)) - 32'sd32768, 0, 0, 250);

        drain_pipe();
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
